FILE: hw/rtl/contact_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Contact table engine assertion macros
// Assertion wrappers shared by the contact table RTL. Define ASSERT_OFF to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef CONTACT_TABLE_ENGINE_DEFINES_SVH
`define CONTACT_TABLE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every clock edge out of reset.
`define CTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds out of reset.
`define CTE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTE_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

FILE: hw/rtl/cte_pkg.sv
// ----------------------------------------------------------------------------
// Contact table engine package
// Request, response and entry types plus operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned NUMBER_W = 50;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned HELD_W   = 7;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_ADD         = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIND_NAME   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_NUMBER = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UPDATE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DELETE      = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [KEY_W-1:0]    name_key;
    logic [NUMBER_W-1:0] phone_number;
  } cte_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_W-1:0]    found_key;
    logic [NUMBER_W-1:0] found_number;
    logic [HELD_W-1:0]   entries_held;
  } cte_rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0]    name_key;
    logic [NUMBER_W-1:0] phone_number;
  } cte_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/contact_table_engine.sv
// ----------------------------------------------------------------------------
// Contact table engine
// Ordered key/number table with add, find, update and delete operations.
// ----------------------------------------------------------------------------
// Issue an item by raising start while busy is low; the item is taken at that
// clock edge. Exactly one result comes back per item on rsp_o, marked by
// done_o for one cycle, and the receiver cannot stall it, so capture it when
// done_o is high. Add, a full table, an empty-table search and an unused mode
// answer in the cycle after the item is taken and leave busy low, so the next
// item may follow at once. Find, update and delete walk the table one entry
// per cycle through the single read port of the entry store, and busy drops
// as the result goes out. Delete then keeps busy high while it moves the
// later entries down, one per cycle, so a delete that hits holds busy for the
// same span wherever the match lies. With a full table, a search that misses
// or hits the last entry and any delete that hits are the longest items. The
// store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contact_table_engine_defines.svh"

module contact_table_engine import cte_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cte_req_t req_i,
  output logic     done_o,
  output cte_rsp_t rsp_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      ptr_q, ptr_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q, done_d;
  cte_rsp_t              rsp_q, rsp_d;

  // request held for the length of the walk
  logic [MODE_W-1:0]     mode_q;
  logic [KEY_W-1:0]      key_q;
  logic [NUMBER_W-1:0]   num_q;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  cte_entry_t            wdata;
  logic [IDX_W-1:0]      raddr;
  cte_entry_t            rdata;
  logic                  hit;

  logic [CNT_W-1:0]      ptr_nxt;
  logic [CNT_W-1:0]      ptr_nxt2;
  logic                  accept;

  // Fold the count and index into the fixed result field widths.
  function automatic logic [HELD_W-1:0] to_held(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[HELD_W-1:0];
  endfunction

  function automatic logic [INDEX_W-1:0] to_index(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[INDEX_W-1:0];
  endfunction

  function automatic cte_rsp_t miss_rsp(input logic [STATUS_W-1:0] st,
                                        input logic [CNT_W-1:0] c);
    cte_rsp_t r;
    r.status       = st;
    r.entry_index  = '0;
    r.found_key    = '0;
    r.found_number = '0;
    r.entries_held = to_held(c);
    return r;
  endfunction

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign ptr_nxt  = CNT_W'(ptr_q) + CNT_W'(1);
  assign ptr_nxt2 = ptr_nxt + CNT_W'(1);

  cte_store #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cte_match u_match (
    .entry_i     (rdata),
    .by_number_i (mode_q == MODE_FIND_NUMBER),
    .key_i       (key_q),
    .number_i    (num_q),
    .hit_o       (hit)
  );

  // Sequencer: one table entry per cycle through the shared compare unit.
  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    count_d = count_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = ptr_q;
    wdata   = rdata;
    // prefetch the next entry by default
    raddr   = ptr_nxt[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.mode)
            MODE_ADD: begin
              done_d = 1'b1;
              if (count_q == CAP_CNT) begin
                rsp_d = miss_rsp(STATUS_FULL, count_q);
              end else begin
                // append at the tail
                we                 = 1'b1;
                waddr              = count_q[IDX_W-1:0];
                wdata.name_key     = req_i.name_key;
                wdata.phone_number = req_i.phone_number;
                count_d            = count_q + CNT_W'(1);
                rsp_d.status       = STATUS_DONE;
                rsp_d.entry_index  = to_index(count_q[IDX_W-1:0]);
                rsp_d.found_key    = req_i.name_key;
                rsp_d.found_number = req_i.phone_number;
                rsp_d.entries_held = to_held(count_q + CNT_W'(1));
              end
            end
            MODE_FIND_NAME, MODE_FIND_NUMBER, MODE_UPDATE, MODE_DELETE: begin
              if (count_q == '0) begin
                done_d = 1'b1;
                rsp_d  = miss_rsp(STATUS_NOT_FOUND, count_q);
              end else begin
                // start the walk at the head
                raddr   = '0;
                ptr_d   = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = miss_rsp(STATUS_NOT_FOUND, count_q);
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          done_d             = 1'b1;
          rsp_d.status       = STATUS_DONE;
          rsp_d.entry_index  = to_index(ptr_q);
          rsp_d.found_key    = rdata.name_key;
          rsp_d.found_number = rdata.phone_number;
          rsp_d.entries_held = to_held(count_q);
          state_d            = ST_IDLE;
          if (mode_q == MODE_UPDATE) begin
            // overwrite the number in place
            we                 = 1'b1;
            wdata.phone_number = num_q;
            rsp_d.found_number = num_q;
          end else if (mode_q == MODE_DELETE) begin
            count_d            = count_q - CNT_W'(1);
            rsp_d.entries_held = to_held(count_q - CNT_W'(1));
            // compact only if later entries exist
            if (ptr_nxt < count_q) begin
              state_d = ST_SHIFT;
            end
          end
        end else if (ptr_nxt == count_q) begin
          done_d  = 1'b1;
          rsp_d   = miss_rsp(STATUS_NOT_FOUND, count_q);
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_nxt[IDX_W-1:0];
        end
      end

      ST_SHIFT: begin
        // move entry ptr+1 down to ptr; count already holds the new total
        we    = 1'b1;
        ptr_d = ptr_nxt[IDX_W-1:0];
        if (ptr_nxt < count_q) begin
          raddr = ptr_nxt2[IDX_W-1:0];
        end else begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.name_key;
      num_q  <= req_i.phone_number;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CTE_ASSERT(a_count_in_range, clk_i, rst_ni, count_q <= CAP_CNT, "entry count beyond capacity")
  `CTE_ASSERT(a_add_ack, clk_i, rst_ni, accept && req_i.mode == MODE_ADD && count_q != CAP_CNT |=> done_o && rsp_o.status == STATUS_DONE && count_q == $past(count_q) + CNT_W'(1), "add not acknowledged")
  `CTE_ASSERT(a_shift_quiet, clk_i, rst_ni, state_q == ST_SHIFT |=> !done_o, "result raised during compaction")
  `CTE_ASSERT(a_miss_zero, clk_i, rst_ni, done_o && rsp_o.status != STATUS_DONE |-> rsp_o.entry_index == '0 && rsp_o.found_key == '0 && rsp_o.found_number == '0, "failed item carries entry data")
  `CTE_ASSERT_NEVER(a_scan_empty, clk_i, rst_ni, state_q == ST_SCAN && count_q == '0, "walk over an empty table")

endmodule

`default_nettype wire

FILE: hw/rtl/cte_store.sv
// ----------------------------------------------------------------------------
// Contact table entry store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_store import cte_pkg::*; #(
  parameter int unsigned CAPACITY = 64,
  parameter int unsigned ADDR_W   = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  cte_entry_t        wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output cte_entry_t        rdata_o
);

  cte_entry_t mem_q [CAPACITY];
  cte_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cte_match.sv
// ----------------------------------------------------------------------------
// Contact table match unit
// Compares one stored entry against the search key or number.
// ----------------------------------------------------------------------------
`default_nettype none

module cte_match import cte_pkg::*; (
  input  cte_entry_t          entry_i,
  input  logic                by_number_i,
  input  logic [KEY_W-1:0]    key_i,
  input  logic [NUMBER_W-1:0] number_i,
  output logic                hit_o
);

  // compare on the number field only for find-by-number
  assign hit_o = by_number_i ? (entry_i.phone_number == number_i)
                             : (entry_i.name_key == key_i);

endmodule

`default_nettype wire
